// ----- rtl/lfp_pkg.sv -----
package lfp_pkg;

    localparam int CHAN_W  = 10;
    localparam int CSUM_W  = 12;
    localparam int ERR_W   = 11;
    localparam int SUM_W   = 16;
    localparam int DERIV_W = 12;
    localparam int GAIN_W  = 16;
    localparam int PP_W    = GAIN_W + ERR_W;
    localparam int PI_W    = GAIN_W + SUM_W;
    localparam int PD_W    = GAIN_W + DERIV_W;
    localparam int ACC_W   = 34;
    localparam int MAG_W   = 15;
    localparam int Q_W     = 8;
    localparam int MIX_W   = 10;
    localparam int PWR_W   = 8;

    // Division by 3 of the channel sum (at most 3069) as a reciprocal product.
    localparam int DIV3_PROD_W = 24;
    localparam logic [DIV3_PROD_W-1:0] DIV3_MUL = DIV3_PROD_W'(2731);
    localparam int DIV3_SHIFT = 13;

    // Division by 100 of a magnitude below 20001, exact over that range.
    localparam int DIV100_PROD_W = 28;
    localparam logic [DIV100_PROD_W-1:0] DIV100_MUL = DIV100_PROD_W'(5243);
    localparam int DIV100_SHIFT = 19;

    // Any turn of 200 or more saturates both motors, so larger values are capped.
    localparam logic [ACC_W-1:0] TURN_MAG_LIMIT = ACC_W'(20000);
    localparam logic signed [MIX_W-1:0] POWER_MAX = MIX_W'(100);
    localparam logic signed [MIX_W-1:0] POWER_MIN = -MIX_W'(100);

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    localparam logic [2:0] REG_OFFSET_LEFT  = 3'd0;
    localparam logic [2:0] REG_OFFSET_RIGHT = 3'd1;
    localparam logic [2:0] REG_GAIN_P_LEFT  = 3'd2;
    localparam logic [2:0] REG_GAIN_I_LEFT  = 3'd3;
    localparam logic [2:0] REG_GAIN_D_LEFT  = 3'd4;
    localparam logic [2:0] REG_GAIN_P_RIGHT = 3'd5;
    localparam logic [2:0] REG_GAIN_I_RIGHT = 3'd6;
    localparam logic [2:0] REG_GAIN_D_RIGHT = 3'd7;

    localparam logic [CHAN_W-1:0] OFFSET_LEFT_RESET  = CHAN_W'(278);
    localparam logic [CHAN_W-1:0] OFFSET_RIGHT_RESET = CHAN_W'(366);

    typedef struct packed {
        logic signed [GAIN_W-1:0] p;
        logic signed [GAIN_W-1:0] i;
        logic signed [GAIN_W-1:0] d;
    } gain_set_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]   err;
        logic signed [SUM_W-1:0]   sum;
        logic signed [DERIV_W-1:0] deriv;
        logic                      left;
    } err_item_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             left;
    } turn_item_t;

endpackage

// ----- rtl/lfp_err.sv -----
module lfp_err
    import lfp_pkg::*;
#(
    parameter int SUM_CEILING = 1000,
    parameter int SUM_FLOOR   = -1000
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAN_W-1:0] in_red,
    input  logic [CHAN_W-1:0] in_green,
    input  logic [CHAN_W-1:0] in_blue,
    input  logic              in_left,
    input  logic [CHAN_W-1:0] left_midpoint,
    input  logic [CHAN_W-1:0] right_midpoint,
    output logic              out_valid,
    input  logic              out_ready,
    output err_item_t         out_item
);

    localparam logic signed [SUM_W:0] CEIL_EXT  = (SUM_W + 1)'(SUM_CEILING);
    localparam logic signed [SUM_W:0] FLOOR_EXT = (SUM_W + 1)'(SUM_FLOOR);

    logic                      va_reg;
    logic [CSUM_W-1:0]         chsum_reg;
    logic                      left_a_reg;
    logic                      vb_reg;
    err_item_t                 item_reg;
    logic signed [SUM_W-1:0]   error_sum_reg;
    logic signed [ERR_W-1:0]   prev_err_reg;

    logic                      ready_a;
    logic                      ready_b;
    logic [DIV3_PROD_W-1:0]    prod3;
    logic [CHAN_W-1:0]         level;
    logic [CHAN_W-1:0]         offset_sel;
    logic signed [ERR_W-1:0]   err;
    logic signed [SUM_W:0]     sum_raw;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [DERIV_W-1:0] deriv;

    assign ready_b  = !vb_reg || out_ready;
    assign ready_a  = !va_reg || ready_b;
    assign in_ready = ready_a;

    assign prod3      = DIV3_PROD_W'(chsum_reg) * DIV3_MUL;
    assign level      = CHAN_W'(prod3 >> DIV3_SHIFT);
    assign offset_sel = left_a_reg ? left_midpoint : right_midpoint;
    assign err        = $signed({1'b0, level}) - $signed({1'b0, offset_sel});
    assign sum_raw    = $signed({error_sum_reg[SUM_W-1], error_sum_reg})
                      + $signed({{(SUM_W + 1 - ERR_W){err[ERR_W-1]}}, err});
    assign deriv      = $signed({err[ERR_W-1], err})
                      - $signed({prev_err_reg[ERR_W-1], prev_err_reg});

    // The integral saturates at the bounds and the clamped value is kept.
    always_comb begin
        priority if (sum_raw > CEIL_EXT) begin
            sum_next = SUM_W'(CEIL_EXT);
        end else if (sum_raw < FLOOR_EXT) begin
            sum_next = SUM_W'(FLOOR_EXT);
        end else begin
            sum_next = SUM_W'(sum_raw);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg        <= 1'b0;
            vb_reg        <= 1'b0;
            error_sum_reg <= '0;
            prev_err_reg  <= '0;
        end else begin
            if (ready_a) begin
                va_reg <= in_valid;
            end
            if (ready_b) begin
                vb_reg <= va_reg;
            end
            if (va_reg && ready_b) begin
                error_sum_reg <= sum_next;
                prev_err_reg  <= err;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && ready_a) begin
            chsum_reg  <= CSUM_W'(in_red) + CSUM_W'(in_green) + CSUM_W'(in_blue);
            left_a_reg <= in_left;
        end
        if (va_reg && ready_b) begin
            item_reg.err   <= err;
            item_reg.sum   <= sum_next;
            item_reg.deriv <= deriv;
            item_reg.left  <= left_a_reg;
        end
    end

    assign out_valid = vb_reg;
    assign out_item  = item_reg;

endmodule

// ----- rtl/lfp_turn.sv -----
module lfp_turn
    import lfp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  err_item_t  in_item,
    input  gain_set_t  gains_left,
    input  gain_set_t  gains_right,
    output logic       out_valid,
    input  logic       out_ready,
    output turn_item_t out_item
);

    logic                    vc_reg;
    logic signed [PP_W-1:0]  pp_reg;
    logic signed [PI_W-1:0]  pi_reg;
    logic signed [PD_W-1:0]  pd_reg;
    logic                    left_c_reg;
    logic                    vd_reg;
    turn_item_t              item_reg;

    logic                    ready_c;
    logic                    ready_d;
    gain_set_t               gsel;
    logic signed [PP_W-1:0]  pp;
    logic signed [PI_W-1:0]  pi;
    logic signed [PD_W-1:0]  pd;
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-1:0]        acc_abs;
    logic [MAG_W-1:0]        mag;

    assign ready_d  = !vd_reg || out_ready;
    assign ready_c  = !vc_reg || ready_d;
    assign in_ready = ready_c;

    assign gsel = in_item.left ? gains_left : gains_right;
    assign pp   = gsel.p * in_item.err;
    assign pi   = gsel.i * in_item.sum;
    assign pd   = gsel.d * in_item.deriv;

    assign acc     = ACC_W'(pp_reg) + ACC_W'(pi_reg) + ACC_W'(pd_reg);
    assign acc_abs = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
    assign mag     = (acc_abs >= TURN_MAG_LIMIT) ? MAG_W'(TURN_MAG_LIMIT)
                                                 : acc_abs[MAG_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (ready_c) begin
                vc_reg <= in_valid;
            end
            if (ready_d) begin
                vd_reg <= vc_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && ready_c) begin
            pp_reg     <= pp;
            pi_reg     <= pi;
            pd_reg     <= pd;
            left_c_reg <= in_item.left;
        end
        if (vc_reg && ready_d) begin
            item_reg.mag  <= mag;
            item_reg.neg  <= acc[ACC_W-1];
            item_reg.left <= left_c_reg;
        end
    end

    assign out_valid = vd_reg;
    assign out_item  = item_reg;

endmodule

// ----- rtl/lfp_mix.sv -----
module lfp_mix
    import lfp_pkg::*;
#(
    parameter int BASE_SPEED = 70
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  turn_item_t           in_item,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [2*PWR_W-1:0]   m_tdata
);

    localparam logic signed [MIX_W-1:0] BASE = MIX_W'(BASE_SPEED);

    logic                     valid_reg;
    logic [2*PWR_W-1:0]       data_reg;

    logic                     ready_e;
    logic [DIV100_PROD_W-1:0] prod100;
    logic [Q_W-1:0]           q;
    logic signed [MIX_W-1:0]  turn;
    logic signed [MIX_W-1:0]  lp;
    logic signed [MIX_W-1:0]  rp;
    logic signed [PWR_W-1:0]  lp_sat;
    logic signed [PWR_W-1:0]  rp_sat;

    function automatic logic signed [PWR_W-1:0] sat_power(input logic signed [MIX_W-1:0] p);
        logic signed [MIX_W-1:0] r;
        begin
            r = p;
            if (p > POWER_MAX) begin
                r = POWER_MAX;
            end else if (p < POWER_MIN) begin
                r = POWER_MIN;
            end
            return PWR_W'(r);
        end
    endfunction

    assign ready_e  = !valid_reg || m_tready;
    assign in_ready = ready_e;

    // The quotient is formed on the magnitude, so it truncates toward zero.
    assign prod100 = DIV100_PROD_W'(in_item.mag) * DIV100_MUL;
    assign q       = Q_W'(prod100 >> DIV100_SHIFT);
    assign turn    = in_item.neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
    assign lp      = in_item.left ? BASE + turn : BASE - turn;
    assign rp      = in_item.left ? BASE - turn : BASE + turn;
    assign lp_sat  = sat_power(lp);
    assign rp_sat  = sat_power(rp);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ready_e) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && ready_e) begin
            data_reg <= {rp_sat, lp_sat};
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// ----- rtl/line_follow_pid.sv -----
// Line-following PID steering.
// Input stream (s_*): one item per color sample, red/green/blue readings in
// s_tdata and the tracking side in s_tuser (1 = left sensor tracks the line).
// Output stream (m_*): one item per input item, left and right motor power
// as signed percent in [-100, 100], in input order.
// Configuration: APB port, eight 32-bit registers at byte addresses 0x00 to
// 0x1C (two sensor offsets, then P/I/D gains for left and right tracking).
// Write it only while no item is in flight.
// Each result passes six registers on its way from input to output: input
// register, channel sum, error and integral update, gain products, turn
// magnitude, output register. Throughput: one item per cycle while m_tready
// stays high; every stage has its own valid flag, so the block keeps accepting
// while bubbles remain.
// When m_tready is low the result holds in the output register and the
// stages behind it fill up; s_tready falls only once all six are full.
// Reset clears every valid flag, the integral and the previous error, and
// loads the register defaults (offsets 278 and 366, all gains zero).
module line_follow_pid
    import lfp_pkg::*;
#(
    parameter int SUM_CEILING = 1000,
    parameter int SUM_FLOOR   = -1000,
    parameter int BASE_SPEED  = 70
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [31:0]       s_tdata,   // red_level, green_level, blue_level, zero pad
    input  logic              s_tuser,   // tracking_on_left
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [15:0]       m_tdata,   // left_power, right_power
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic              v0_reg;
    logic [CHAN_W-1:0] red_reg;
    logic [CHAN_W-1:0] green_reg;
    logic [CHAN_W-1:0] blue_reg;
    logic              left_reg;

    logic [CHAN_W-1:0] left_mid_reg;
    logic [CHAN_W-1:0] right_mid_reg;
    gain_set_t         gains_left_reg;
    gain_set_t         gains_right_reg;

    logic              err_ready;
    logic              err_valid;
    err_item_t         err_item;
    logic              turn_ready;
    logic              turn_valid;
    turn_item_t        turn_item;
    logic              mix_ready;
    logic              cfg_write;
    logic [2:0]        reg_idx;

    assign s_tready  = !v0_reg || err_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (s_tready) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            red_reg   <= s_tdata[CHAN_W-1:0];
            green_reg <= s_tdata[2*CHAN_W-1:CHAN_W];
            blue_reg  <= s_tdata[3*CHAN_W-1:2*CHAN_W];
            left_reg  <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_mid_reg    <= OFFSET_LEFT_RESET;
            right_mid_reg   <= OFFSET_RIGHT_RESET;
            gains_left_reg  <= '0;
            gains_right_reg <= '0;
        end else if (cfg_write) begin
            unique case (reg_idx)
                REG_OFFSET_LEFT:  left_mid_reg      <= pwdata[CHAN_W-1:0];
                REG_OFFSET_RIGHT: right_mid_reg     <= pwdata[CHAN_W-1:0];
                REG_GAIN_P_LEFT:  gains_left_reg.p  <= $signed(pwdata[GAIN_W-1:0]);
                REG_GAIN_I_LEFT:  gains_left_reg.i  <= $signed(pwdata[GAIN_W-1:0]);
                REG_GAIN_D_LEFT:  gains_left_reg.d  <= $signed(pwdata[GAIN_W-1:0]);
                REG_GAIN_P_RIGHT: gains_right_reg.p <= $signed(pwdata[GAIN_W-1:0]);
                REG_GAIN_I_RIGHT: gains_right_reg.i <= $signed(pwdata[GAIN_W-1:0]);
                REG_GAIN_D_RIGHT: gains_right_reg.d <= $signed(pwdata[GAIN_W-1:0]);
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_OFFSET_LEFT:  prdata = DATA_W'(left_mid_reg);
            REG_OFFSET_RIGHT: prdata = DATA_W'(right_mid_reg);
            REG_GAIN_P_LEFT:  prdata = DATA_W'(gains_left_reg.p);
            REG_GAIN_I_LEFT:  prdata = DATA_W'(gains_left_reg.i);
            REG_GAIN_D_LEFT:  prdata = DATA_W'(gains_left_reg.d);
            REG_GAIN_P_RIGHT: prdata = DATA_W'(gains_right_reg.p);
            REG_GAIN_I_RIGHT: prdata = DATA_W'(gains_right_reg.i);
            REG_GAIN_D_RIGHT: prdata = DATA_W'(gains_right_reg.d);
        endcase
    end

    lfp_err #(
        .SUM_CEILING (SUM_CEILING),
        .SUM_FLOOR   (SUM_FLOOR)
    ) u_err (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (v0_reg),
        .in_ready       (err_ready),
        .in_red         (red_reg),
        .in_green       (green_reg),
        .in_blue        (blue_reg),
        .in_left        (left_reg),
        .left_midpoint  (left_mid_reg),
        .right_midpoint (right_mid_reg),
        .out_valid      (err_valid),
        .out_ready      (turn_ready),
        .out_item       (err_item)
    );

    lfp_turn u_turn (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (err_valid),
        .in_ready    (turn_ready),
        .in_item     (err_item),
        .gains_left  (gains_left_reg),
        .gains_right (gains_right_reg),
        .out_valid   (turn_valid),
        .out_ready   (mix_ready),
        .out_item    (turn_item)
    );

    lfp_mix #(
        .BASE_SPEED (BASE_SPEED)
    ) u_mix (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (turn_valid),
        .in_ready (mix_ready),
        .in_item  (turn_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ----- rtl/lfp_checker.sv -----
module lfp_checker #(
    parameter int BASE_SPEED = 70
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    logic signed [7:0] lp;
    logic signed [7:0] rp;
    logic              lp_free;
    logic              rp_free;

    assign lp      = $signed(m_tdata[7:0]);
    assign rp      = $signed(m_tdata[15:8]);
    assign lp_free = (lp > -8'sd100) && (lp < 8'sd100);
    assign rp_free = (rp > -8'sd100) && (rp < 8'sd100);

    // Reset empties the pipeline, so no result may follow it directly.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_power_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (lp >= -8'sd100) && (lp <= 8'sd100)
                  && (rp >= -8'sd100) && (rp <= 8'sd100))
        else $error("motor power outside saturation bounds");

    // Unsaturated powers are mirrored around the base speed.
    a_mirror: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && lp_free && rp_free) |-> (int'(lp) + int'(rp) == 2 * BASE_SPEED))
        else $error("left and right power not mirrored around base speed");

    // A free output side means every stage can move.
    a_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output side is ready");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

endmodule

bind line_follow_pid lfp_checker #(
    .BASE_SPEED (BASE_SPEED)
) u_lfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
